>>> rtl/core/image_rotate_bilinear_q9_top_assert.svh
// Assertion macros for the bilinear rotation engine.
// Used by modules that have clk and arst_n in scope; no other dependencies.
`ifndef IMAGE_ROTATE_BILINEAR_Q9_TOP_ASSERT_SVH
`define IMAGE_ROTATE_BILINEAR_Q9_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/irb_pkg.sv
// Shared constants, types and register codes of the bilinear rotation engine.
// No dependencies; imported by the interfaces, the frame RAM and the top level.
package irb_pkg;

	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;
	localparam int FRAC_BITS    = 9;

	localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W    = $clog2(PIX_COUNT);
	localparam int ROW_W     = $clog2(FRAME_HEIGHT);
	localparam int COL_W     = $clog2(FRAME_WIDTH);
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF_H    = FRAME_HEIGHT / 2;
	localparam int HALF_W    = FRAME_WIDTH / 2;

	localparam int CFG_W   = 11;
	localparam int COORD_W = 12;
	localparam int PROD_W  = COORD_W + CFG_W;
	localparam int SUM_W   = PROD_W + 3;
	localparam int WGT_W   = FRAC_BITS + 1;
	localparam int WPROD_W = WGT_W + 8;
	localparam int ACC_W   = WPROD_W + 1;

	localparam logic signed [SUM_W-1:0] CTR_ROW_Q = SUM_W'(HALF_H * ONE);
	localparam logic signed [SUM_W-1:0] CTR_COL_Q = SUM_W'(HALF_W * ONE);
	localparam logic signed [SUM_W-1:0] MAX_ROW_Q = SUM_W'((FRAME_HEIGHT - 1) * ONE);
	localparam logic signed [SUM_W-1:0] MAX_COL_Q = SUM_W'((FRAME_WIDTH - 1) * ONE);

	// output queue; depth is a power of two so the pointers wrap on their own
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int CNT_W       = $clog2(OFIFO_DEPTH + 1);

	// APB register map
	localparam int   PADDR_W     = 3;
	localparam int   REG_SEL_BIT = 2;
	localparam logic REG_COS     = 1'b0;
	localparam logic REG_SIN     = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [23:0]       pixel_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_ROTATE = 1'b1
	} op_t;

	typedef struct packed {
		logic   we;
		logic   re;
		addr_t  addr;
		pixel_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic       in_frame;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

endpackage

>>> rtl/core/irb_stream_if.sv
// Valid/ready stream interfaces for the rotation engine's request and result channels.
// Depends on irb_pkg.
interface irb_in_if;
	import irb_pkg::*;

	logic       valid;
	logic       ready;
	logic       operation;
	logic [8:0] pixel_col;
	logic [7:0] pixel_row;
	logic [7:0] load_red;
	logic [7:0] load_green;
	logic [7:0] load_blue;

	modport source (
		output valid, operation, pixel_col, pixel_row, load_red, load_green, load_blue,
		input  ready
	);
	modport sink (
		input  valid, operation, pixel_col, pixel_row, load_red, load_green, load_blue,
		output ready
	);
endinterface

interface irb_out_if;
	import irb_pkg::*;

	logic       valid;
	logic       ready;
	logic       inside_res;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (
		output valid, inside_res, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, inside_res, out_red, out_green, out_blue,
		output ready
	);
endinterface

>>> rtl/core/irb_frame_ram.sv
// Single-port source frame memory, one access per cycle, registered read data.
// Depends on irb_pkg (mem_req_t, pixel_t, PIX_COUNT).
module irb_frame_ram (
	input  logic              clk,
	input  irb_pkg::mem_req_t req,
	output irb_pkg::pixel_t   rd_data
);
	import irb_pkg::*;

	pixel_t frame_mem_q [PIX_COUNT];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			frame_mem_q[req.addr] <= req.wdata;
		end else if (req.re) begin
			rd_data_q <= frame_mem_q[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/image_rotate_bilinear_q9_top.sv
// Bilinear rotation engine top level: mapping pipeline, read sequencer, blend, result queue.
// Depends on irb_pkg, irb_stream_if.sv, irb_frame_ram and the assertion macro header.
//
// Usage:
//  pix_in  carries requests. operation 0 writes one source pixel (out-of-frame loads are
//          dropped); operation 1 asks for one rotated destination pixel.
//  pix_out carries one result per rotate request, in request order; none for loads.
//  APB     cos_q9 at 0x0, sin_q9 at 0x4 (11-bit signed Q9); write only while idle.
// Sequencing: a load or an out-of-frame rotate makes at most one frame memory access; an
//  in-frame rotate makes one read per neighbour, in turn, on the single frame memory port.
// Path: a request passes stages 1 to 3, where the reads are issued, then stages 4 and 5
//  before its result enters the queue; an out-of-frame result passes stages 4 and 5 once.
// Reset: cos_q9 = 512, sin_q9 = 0, pipeline and queue empty. The frame memory is not
//  cleared; a pixel must be loaded before any rotate reads it.
// Stall: results collect in a 4-entry queue. Rotate requests only start their reads
//  while a queue slot is reserved for them, so a stalled receiver backs up into
//  pix_in.ready without losing data; loads keep flowing until the pipeline fills.
`include "image_rotate_bilinear_q9_top_assert.svh"

module image_rotate_bilinear_q9_top (
	input  logic                          clk,
	input  logic                          arst_n,
	irb_in_if.sink                        pix_in,
	irb_out_if.source                     pix_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irb_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import irb_pkg::*;

	// ---------------- configuration ----------------
	logic signed [CFG_W-1:0] cos_q;
	logic signed [CFG_W-1:0] sin_q;
	logic                    apb_wr;

	assign apb_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= CFG_W'(ONE);
			sin_q <= '0;
		end else if (apb_wr) begin
			if (paddr[REG_SEL_BIT] == REG_COS) begin
				cos_q <= pwdata[CFG_W-1:0];
			end else begin
				sin_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[REG_SEL_BIT] == REG_SIN) begin
			prdata = {{(32-CFG_W){sin_q[CFG_W-1]}}, sin_q};
		end else begin
			prdata = {{(32-CFG_W){cos_q[CFG_W-1]}}, cos_q};
		end
	end

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, take3;
	logic go, done, is_rot, credit_ok;
	logic [1:0] k_q;
	logic [CNT_W-1:0] pend_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	// ---------------- stage 1: offsets and products ----------------
	logic signed [COORD_W-1:0] r_in, c_in;
	logic signed [PROD_W-1:0]  p_rc_in, p_cs_in, p_cc_in, p_rs_in;
	addr_t                     ld_addr_in;
	logic                      ld_ok_in;

	logic signed [PROD_W-1:0]  p_rc_s1, p_cs_s1, p_cc_s1, p_rs_s1;
	op_t                       op_s1;
	addr_t                     ld_addr_s1;
	logic                      ld_ok_s1;
	pixel_t                    rgb_s1;

	always_comb begin
		r_in       = COORD_W'(pix_in.pixel_row) - COORD_W'(HALF_H);
		c_in       = COORD_W'(pix_in.pixel_col) - COORD_W'(HALF_W);
		p_rc_in    = r_in * cos_q;
		p_cs_in    = c_in * sin_q;
		p_cc_in    = c_in * cos_q;
		p_rs_in    = r_in * sin_q;
		ld_addr_in = ADDR_W'(pix_in.pixel_row) * ADDR_W'(FRAME_WIDTH)
			+ ADDR_W'(pix_in.pixel_col);
		ld_ok_in   = (int'(pix_in.pixel_col) < FRAME_WIDTH)
			&& (int'(pix_in.pixel_row) < FRAME_HEIGHT);
	end

	assign pix_in.ready = adv1;
	assign adv1         = !v_s1 || adv2;
	assign adv2         = !v_s2 || take3;

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_rc_s1    <= p_rc_in;
			p_cs_s1    <= p_cs_in;
			p_cc_s1    <= p_cc_in;
			p_rs_s1    <= p_rs_in;
			op_s1      <= op_t'(pix_in.operation);
			ld_addr_s1 <= ld_addr_in;
			ld_ok_s1   <= ld_ok_in;
			rgb_s1     <= {pix_in.load_red, pix_in.load_green, pix_in.load_blue};
		end
	end

	// ---------------- stage 2: source coordinate and bounds ----------------
	logic signed [SUM_W-1:0] srow_d, scol_d;
	logic signed [SUM_W-1:0] srow_s2, scol_s2;
	logic                    inside_s2;
	op_t                     op_s2;
	addr_t                   ld_addr_s2;
	logic                    ld_ok_s2;
	pixel_t                  rgb_s2;

	always_comb begin
		srow_d = SUM_W'(p_rc_s1) + SUM_W'(p_cs_s1) + CTR_ROW_Q;
		scol_d = SUM_W'(p_cc_s1) - SUM_W'(p_rs_s1) + CTR_COL_Q;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			srow_s2    <= srow_d;
			scol_s2    <= scol_d;
			inside_s2  <= !srow_d[SUM_W-1] && !scol_d[SUM_W-1]
				&& (srow_d <= MAX_ROW_Q) && (scol_d <= MAX_COL_Q);
			op_s2      <= op_s1;
			ld_addr_s2 <= ld_addr_s1;
			ld_ok_s2   <= ld_ok_s1;
			rgb_s2     <= rgb_s1;
		end
	end

	// ---------------- stage 3: weights, base address, read sequencer ----------------
	logic [ROW_W-1:0]     i_d;
	logic [COL_W-1:0]     j_d;
	logic [FRAC_BITS-1:0] fr_d, fc_d;
	logic [WGT_W-1:0]     omr_d, omc_d, fr_w, fc_w;
	logic [2*WGT_W-1:0]   m00, m01, m10, m11;
	addr_t                base_d;

	logic [WGT_W-1:0] wgt_s3 [4];
	op_t              op_s3;
	logic             inside_s3;
	logic             ld_ok_s3;
	addr_t            addr_s3;
	logic             dj_s3, di_s3;
	pixel_t           rgb_s3;
	addr_t            rd_addr;
	mem_req_t         mem_req;
	pixel_t           rd_data;

	always_comb begin
		i_d    = srow_s2[FRAC_BITS +: ROW_W];
		j_d    = scol_s2[FRAC_BITS +: COL_W];
		fr_d   = srow_s2[FRAC_BITS-1:0];
		fc_d   = scol_s2[FRAC_BITS-1:0];
		fr_w   = WGT_W'(fr_d);
		fc_w   = WGT_W'(fc_d);
		omr_d  = WGT_W'(ONE) - fr_w;
		omc_d  = WGT_W'(ONE) - fc_w;
		m00    = omr_d * omc_d;
		m01    = omr_d * fc_w;
		m10    = fr_w * omc_d;
		m11    = fr_w * fc_w;
		base_d = ADDR_W'(i_d) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(j_d);
	end

	always_ff @(posedge clk) begin
		if (take3) begin
			op_s3     <= op_s2;
			inside_s3 <= inside_s2;
			ld_ok_s3  <= ld_ok_s2;
			addr_s3   <= (op_s2 == OP_LOAD) ? ld_addr_s2 : base_d;
			// clamp the right and bottom neighbours to the last column and row
			dj_s3     <= int'(j_d) < FRAME_WIDTH - 1;
			di_s3     <= int'(i_d) < FRAME_HEIGHT - 1;
			wgt_s3[0] <= m00[FRAC_BITS +: WGT_W];
			wgt_s3[1] <= m01[FRAC_BITS +: WGT_W];
			wgt_s3[2] <= m10[FRAC_BITS +: WGT_W];
			wgt_s3[3] <= m11[FRAC_BITS +: WGT_W];
			rgb_s3    <= rgb_s2;
		end
	end

	// k walks p00, p01, p10, p11; a rotate only starts with a reserved result slot
	assign is_rot    = (op_s3 == OP_ROTATE);
	assign credit_ok = pend_q < CNT_W'(OFIFO_DEPTH);
	assign go        = v_s3 && (!is_rot || (k_q != 2'd0) || credit_ok);
	assign done      = go && (!is_rot || !inside_s3 || (&k_q));
	assign take3     = !v_s3 || done;

	always_comb begin
		rd_addr = addr_s3
			+ ((k_q[0] && dj_s3) ? ADDR_W'(1) : ADDR_W'(0))
			+ ((k_q[1] && di_s3) ? ADDR_W'(FRAME_WIDTH) : ADDR_W'(0));
		mem_req.we    = go && !is_rot && ld_ok_s3;
		mem_req.re    = go && is_rot && inside_s3;
		mem_req.addr  = mem_req.we ? addr_s3 : rd_addr;
		mem_req.wdata = rgb_s3;
	end

	irb_frame_ram u_frame_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// ---------------- stage 4: read data arrives ----------------
	logic [WGT_W-1:0] wgt_s4;
	logic             inside_s4, first_s4, last_s4;

	always_ff @(posedge clk) begin
		wgt_s4    <= wgt_s3[k_q];
		inside_s4 <= inside_s3;
		first_s4  <= (k_q == 2'd0);
		last_s4   <= !inside_s3 || (&k_q);
	end

	// ---------------- stage 5: weighted channels ----------------
	logic [WPROD_W-1:0] prod_s5 [3];
	logic               inside_s5, first_s5, last_s5;

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			prod_s5[ch] <= inside_s4 ? wgt_s4 * rd_data[(2-ch)*8 +: 8] : '0;
		end
		inside_s5 <= inside_s4;
		first_s5  <= first_s4;
		last_s5   <= last_s4;
	end

	// ---------------- accumulate and queue ----------------
	logic [ACC_W-1:0] acc_q [3];
	logic [ACC_W-1:0] sum_d [3];
	result_t          res_d;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = (first_s5 ? '0 : acc_q[ch]) + ACC_W'(prod_s5[ch]);
		end
		res_d.in_frame = inside_s5;
		res_d.red      = sum_d[0][FRAC_BITS +: 8];
		res_d.green    = sum_d[1][FRAC_BITS +: 8];
		res_d.blue     = sum_d[2][FRAC_BITS +: 8];
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= sum_d[ch];
			end
		end
	end

	result_t              ofifo_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	result_t              head;

	assign push = v_s5 && last_s5;
	assign pop  = pix_out.valid && pix_out.ready;
	assign head = ofifo_q[rd_ptr_q];

	assign pix_out.valid      = (cnt_q != '0);
	assign pix_out.inside_res = head.in_frame;
	assign pix_out.out_red    = head.red;
	assign pix_out.out_green  = head.green;
	assign pix_out.out_blue   = head.blue;

	always_ff @(posedge clk) begin
		if (push) begin
			ofifo_q[wr_ptr_q] <= res_d;
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			k_q      <= '0;
			pend_q   <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (adv1) begin
				v_s1 <= pix_in.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (take3) begin
				v_s3 <= v_s2;
			end
			v_s4 <= go && is_rot;
			v_s5 <= v_s4;
			if (done) begin
				k_q <= '0;
			end else if (go && is_rot) begin
				k_q <= k_q + 2'd1;
			end
			pend_q <= pend_q + CNT_W'(go && is_rot && (k_q == 2'd0)) - CNT_W'(pop);
			cnt_q  <= cnt_q + CNT_W'(push) - CNT_W'(pop);
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_AW'(1);
			end
		end
	end

	// ---------------- assertions ----------------
	`IRB_ASSERT_IMP(a_queue_no_overflow, push, (cnt_q != CNT_W'(OFIFO_DEPTH)) || pop, "result queue overflow")
	`IRB_ASSERT_IMP(a_slots_reserved, 1'b1, pend_q >= cnt_q, "queued results exceed reserved slots")
	`IRB_ASSERT_IMP(a_write_only_load, mem_req.we, !mem_req.re && v_s3 && (op_s3 == OP_LOAD), "frame write outside a load")
	`IRB_ASSERT_IMP(a_seq_only_inside, k_q != 2'd0, v_s3 && is_rot && inside_s3, "read sequencer active without an in-frame rotate")
	`IRB_ASSERT_NXT(a_seq_holds, v_s3 && !take3, v_s3 && $stable(addr_s3), "sequencer lost its item")

endmodule
